>>> hdl/pvr_pkg.sv
// shared types, constants and arithmetic helpers for the bin resynthesis block
`default_nettype none

package pvr_pkg;

    // field widths
    localparam int BIN_W   = 11;
    localparam int MAG_W   = 16;
    localparam int FREQ_W  = 24;
    localparam int SCALE_W = 48;
    localparam int PHASE_W = 32;
    localparam int OUT_W   = 17;
    localparam int Q15_W   = 16;
    localparam int X_W     = 30;
    localparam int OCT_W   = 3;

    // default number of bins with a phase accumulator
    localparam int NUM_BINS_DEF = 1025;

    // trig constants
    localparam logic [32:0]        HALF_PI_Q32 = 33'd6746518852;
    localparam logic [X_W-1:0]     OCT_SIZE    = 30'd536870912;
    localparam logic [PHASE_W-1:0] ONE_Q30     = 32'd1073741824;
    localparam logic [PHASE_W-1:0] RND_Q15     = 32'd16384;

    // reciprocal constants for exact floor division of values below 2^30
    localparam int RCP6_K     = 33;
    localparam int RCP24_K    = 35;
    localparam int RCP120_K   = 37;
    localparam int RCP720_K   = 40;
    localparam int RCP5040_K  = 43;
    localparam int RCP40320_K = 46;
    localparam logic [31:0] RCP6_M     = 32'(((64'd1 << RCP6_K) + 64'd5) / 64'd6);
    localparam logic [31:0] RCP24_M    = 32'(((64'd1 << RCP24_K) + 64'd23) / 64'd24);
    localparam logic [31:0] RCP120_M   = 32'(((64'd1 << RCP120_K) + 64'd119) / 64'd120);
    localparam logic [31:0] RCP720_M   = 32'(((64'd1 << RCP720_K) + 64'd719) / 64'd720);
    localparam logic [31:0] RCP5040_M  = 32'(((64'd1 << RCP5040_K) + 64'd5039) / 64'd5040);
    localparam logic [31:0] RCP40320_M = 32'(((64'd1 << RCP40320_K) + 64'd40319) / 64'd40320);

    // input beat
    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [MAG_W-1:0]  mag;
        logic [FREQ_W-1:0] freq;
        logic              fresh;
    } in_beat_t;

    // beat after phase accumulation
    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic [MAG_W-1:0]   mag;
        logic [PHASE_W-1:0] phase;
    } phs_beat_t;

    // side data carried along the trig pipeline
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
        logic [OCT_W-1:0] oct;
    } tag_t;

    // beat after octant sine and cosine
    typedef struct packed {
        tag_t             tag;
        logic [Q15_W-1:0] s15;
        logic [Q15_W-1:0] c15;
    } trig_beat_t;

    // q30 product of two values below one
    function automatic logic [X_W-1:0] q30_mul(input logic [X_W-1:0] a,
                                               input logic [X_W-1:0] b);
        logic [2*X_W-1:0] p;
        p = (2*X_W)'(a) * (2*X_W)'(b);
        return p[2*X_W-1:X_W];
    endfunction

    // floor division by a constant through its reciprocal
    function automatic logic [X_W-1:0] rcp_div(input logic [X_W-1:0] v,
                                               input logic [31:0] m,
                                               input int k);
        logic [X_W+31:0] p;
        p = (X_W+32)'(v) * (X_W+32)'(m);
        return X_W'(p >> k);
    endfunction

endpackage

`default_nettype wire

>>> hdl/pvr_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module pvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and read-first registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/pvr_phase.sv
// phase advance, per-bin accumulator ram with forwarding and reset clearing pass
`default_nettype none

module pvr_phase #(
    parameter int NUM_BINS = pvr_pkg::NUM_BINS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic [pvr_pkg::SCALE_W-1:0]  cfg_data,
    input  wire logic                         up_valid,
    output logic                              up_ready,
    input  wire pvr_pkg::in_beat_t            up_beat,
    output logic                              dn_valid,
    input  wire logic                         dn_ready,
    output pvr_pkg::phs_beat_t                dn_beat
);

    import pvr_pkg::*;

    localparam int AW = $clog2(NUM_BINS);

    // configuration and clearing pass
    logic [SCALE_W-1:0] scale_reg;
    logic               clr_busy_reg;
    logic [AW-1:0]      clr_cnt_reg;

    // stage valids and enables
    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic en1, en2, en3;

    // stage 1: input beat
    in_beat_t s1_beat_reg;

    // stage 2: partial products
    logic [BIN_W-1:0]   s2_bin_reg;
    logic [MAG_W-1:0]   s2_mag_reg;
    logic               s2_fresh_reg;
    logic               s2_inr_reg;
    logic [PHASE_W-1:0] s2_phi_reg;
    logic [FREQ_W-1:0]  s2_plo_reg;
    logic [2*FREQ_W-1:0] p_hi;
    logic [2*FREQ_W-1:0] p_lo;
    logic               inr_next;

    // stage 3: advance, forwarding, accumulate
    logic [BIN_W-1:0]   s3_bin_reg;
    logic [MAG_W-1:0]   s3_mag_reg;
    logic               s3_fresh_reg;
    logic               s3_inr_reg;
    logic [PHASE_W-1:0] s3_adv_reg;
    logic               s3_hit_reg;
    logic [PHASE_W-1:0] s3_fwd_reg;
    logic [PHASE_W-1:0] adv_next;
    logic               hit_next;
    logic [PHASE_W-1:0] base;
    logic [PHASE_W-1:0] phase;

    // ram ports
    logic               item_we;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [PHASE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [PHASE_W-1:0] ram_rdata;

    // enable chain from the downstream side
    assign en3      = !s3_v_reg || dn_ready;
    assign en2      = !s2_v_reg || en3;
    assign en1      = !s1_v_reg || en2;
    assign up_ready = en1 && !clr_busy_reg;

    // advance partial products
    assign p_hi     = (2*FREQ_W)'(s1_beat_reg.freq) * (2*FREQ_W)'(scale_reg[SCALE_W-1:FREQ_W]);
    assign p_lo     = (2*FREQ_W)'(s1_beat_reg.freq) * (2*FREQ_W)'(scale_reg[FREQ_W-1:0]);
    assign inr_next = 32'(s1_beat_reg.bin) < 32'(NUM_BINS);

    // advance sum
    assign adv_next = s2_phi_reg + PHASE_W'(s2_plo_reg);

    // accumulate with bypass of the write made as this beat's read went out
    assign base  = s3_fresh_reg ? '0 : (s3_hit_reg ? s3_fwd_reg : ram_rdata);
    assign phase = s3_inr_reg ? base + s3_adv_reg : s3_adv_reg;

    assign item_we  = s3_v_reg && dn_ready && s3_inr_reg;
    assign hit_next = item_we && (s3_bin_reg == s2_bin_reg);

    // ram port muxing between clearing pass and accumulate
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = item_we;
            ram_waddr = AW'(s3_bin_reg);
            ram_wdata = phase;
        end
    end

    assign ram_re    = en3 && s2_v_reg;
    assign ram_raddr = AW'(s2_bin_reg);

    pvr_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (NUM_BINS)
    ) u_pvr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= '0;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                scale_reg <= cfg_data;
            end
            if (clr_busy_reg)
            begin
                if (clr_cnt_reg == AW'(NUM_BINS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
            end
            if (en1)
            begin
                s1_v_reg <= up_valid && !clr_busy_reg;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_beat_reg <= up_beat;
        end
        if (en2)
        begin
            s2_bin_reg   <= s1_beat_reg.bin;
            s2_mag_reg   <= s1_beat_reg.mag;
            s2_fresh_reg <= s1_beat_reg.fresh;
            s2_inr_reg   <= inr_next;
            s2_phi_reg   <= p_hi[PHASE_W-1:0];
            s2_plo_reg   <= p_lo[2*FREQ_W-1:FREQ_W];
        end
        if (en3)
        begin
            s3_bin_reg   <= s2_bin_reg;
            s3_mag_reg   <= s2_mag_reg;
            s3_fresh_reg <= s2_fresh_reg;
            s3_inr_reg   <= s2_inr_reg;
            s3_adv_reg   <= adv_next;
            s3_hit_reg   <= hit_next;
            s3_fwd_reg   <= phase;
        end
    end

    // downstream beat
    always_comb
    begin
        dn_beat.bin   = s3_bin_reg;
        dn_beat.mag   = s3_mag_reg;
        dn_beat.phase = phase;
    end

    assign dn_valid = s3_v_reg;

endmodule

`default_nettype wire

>>> hdl/pvr_trig.sv
// octant fold and pipelined taylor series for sine and cosine in q1.15
`default_nettype none

module pvr_trig (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire pvr_pkg::phs_beat_t   up_beat,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output pvr_pkg::trig_beat_t       dn_beat
);

    import pvr_pkg::*;

    localparam int NST = 9;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    // stage registers
    phs_beat_t          t1_beat_reg;
    tag_t               tag_reg [1:NST-1];
    logic [X_W-1:0]     t_reg;
    logic [X_W-1:0]     x_reg;
    logic [X_W-1:0]     x2_reg, xa_reg;
    logic [X_W-1:0]     x3_reg, x4_reg, xb_reg, x2b_reg;
    logic [X_W-1:0]     x5_reg, x6_reg, x8_reg, d3_reg, d4_reg, h2_reg, xc_reg;
    logic [X_W-1:0]     x7_reg, d5_reg, d6_reg, d8_reg;
    logic [PHASE_W-1:0] sp_reg, cp_reg;
    logic [X_W-1:0]     d7_reg;
    logic [PHASE_W-1:0] sq_reg, cq_reg;
    logic [Q15_W-1:0]   s15_reg, c15_reg;

    // next values
    tag_t               tag1_next;
    logic [X_W-1:0]     t_next;
    logic [62:0]        x_prod;
    logic [X_W-1:0]     x_next;
    logic [X_W-1:0]     x2_next, x3_next, x4_next;
    logic [X_W-1:0]     x5_next, x6_next, x8_next, d3_next, d4_next, h2_next;
    logic [X_W-1:0]     x7_next, d5_next, d6_next, d8_next;
    logic [PHASE_W-1:0] sp_next, cp_next;
    logic [X_W-1:0]     d7_next;
    logic [PHASE_W-1:0] sq_next, cq_next;
    logic [PHASE_W-1:0] s_rnd, c_rnd;

    // enable chain
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || dn_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign up_ready = en[0];

    // octant fold
    assign tag1_next = '{bin: t1_beat_reg.bin, mag: t1_beat_reg.mag,
                         oct: t1_beat_reg.phase[PHASE_W-1:PHASE_W-OCT_W]};
    assign t_next    = t1_beat_reg.phase[PHASE_W-OCT_W] ?
                       OCT_SIZE - X_W'(t1_beat_reg.phase[X_W-2:0]) :
                       X_W'(t1_beat_reg.phase[X_W-2:0]);

    // angle in q30 radians
    assign x_prod = 63'(t_reg) * 63'(HALF_PI_Q32);
    assign x_next = x_prod[61:32];

    // powers and series terms
    assign x2_next = q30_mul(x_reg, x_reg);
    assign x3_next = q30_mul(x2_reg, xa_reg);
    assign x4_next = q30_mul(x2_reg, x2_reg);
    assign x5_next = q30_mul(x4_reg, xb_reg);
    assign x6_next = q30_mul(x4_reg, x2b_reg);
    assign x8_next = q30_mul(x4_reg, x4_reg);
    assign d3_next = rcp_div(x3_reg, RCP6_M, RCP6_K);
    assign d4_next = rcp_div(x4_reg, RCP24_M, RCP24_K);
    assign h2_next = x2b_reg >> 1;
    assign x7_next = q30_mul(x6_reg, xc_reg);
    assign d5_next = rcp_div(x5_reg, RCP120_M, RCP120_K);
    assign d6_next = rcp_div(x6_reg, RCP720_M, RCP720_K);
    assign d8_next = rcp_div(x8_reg, RCP40320_M, RCP40320_K);
    assign sp_next = PHASE_W'(xc_reg) - PHASE_W'(d3_reg);
    assign cp_next = ONE_Q30 + PHASE_W'(d4_reg) - PHASE_W'(h2_reg);
    assign d7_next = rcp_div(x7_reg, RCP5040_M, RCP5040_K);
    assign sq_next = sp_reg + PHASE_W'(d5_reg);
    assign cq_next = cp_reg + PHASE_W'(d8_reg) - PHASE_W'(d6_reg);

    // round to q1.15
    assign s_rnd = sq_reg - PHASE_W'(d7_reg) + RND_Q15;
    assign c_rnd = cq_reg + RND_Q15;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_beat_reg <= up_beat;
        end
        if (en[1])
        begin
            tag_reg[1] <= tag1_next;
            t_reg      <= t_next;
        end
        for (int i = 2; i < NST; i++)
        begin
            if (en[i])
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
        if (en[2])
        begin
            x_reg <= x_next;
        end
        if (en[3])
        begin
            x2_reg <= x2_next;
            xa_reg <= x_reg;
        end
        if (en[4])
        begin
            x3_reg  <= x3_next;
            x4_reg  <= x4_next;
            xb_reg  <= xa_reg;
            x2b_reg <= x2_reg;
        end
        if (en[5])
        begin
            x5_reg <= x5_next;
            x6_reg <= x6_next;
            x8_reg <= x8_next;
            d3_reg <= d3_next;
            d4_reg <= d4_next;
            h2_reg <= h2_next;
            xc_reg <= xb_reg;
        end
        if (en[6])
        begin
            x7_reg <= x7_next;
            d5_reg <= d5_next;
            d6_reg <= d6_next;
            d8_reg <= d8_next;
            sp_reg <= sp_next;
            cp_reg <= cp_next;
        end
        if (en[7])
        begin
            d7_reg <= d7_next;
            sq_reg <= sq_next;
            cq_reg <= cq_next;
        end
        if (en[8])
        begin
            s15_reg <= s_rnd[30:15];
            c15_reg <= c_rnd[30:15];
        end
    end

    // downstream beat
    always_comb
    begin
        dn_beat.tag = tag_reg[NST-1];
        dn_beat.s15 = s15_reg;
        dn_beat.c15 = c15_reg;
    end

    assign dn_valid = v_reg[NST-1];

endmodule

`default_nettype wire

>>> hdl/pvr_scale.sv
// octant placement, magnitude scaling and output register
`default_nettype none

module pvr_scale (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        up_valid,
    output logic                             up_ready,
    input  wire pvr_pkg::trig_beat_t         up_beat,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic        [pvr_pkg::BIN_W-1:0] out_bin,
    output logic signed [pvr_pkg::OUT_W-1:0] real_part,
    output logic signed [pvr_pkg::OUT_W-1:0] imag_part
);

    import pvr_pkg::*;

    logic m1_v_reg, m2_v_reg;
    logic en1, en2;

    // stage 1: scaled magnitudes
    logic [BIN_W-1:0]   m1_bin_reg;
    logic [2*MAG_W-1:0] m1_re_reg, m1_im_reg;
    logic               m1_re_neg_reg, m1_im_neg_reg;

    // stage 2: output register
    logic [BIN_W-1:0] m2_bin_reg;
    logic [OUT_W-1:0] m2_re_reg, m2_im_reg;

    logic               swap;
    logic [Q15_W-1:0]   sin_abs, cos_abs;
    logic [2*MAG_W-1:0] re_next, im_next;
    logic               re_neg_next, im_neg_next;
    logic [OUT_W-1:0]   re_mag, im_mag;
    logic [OUT_W-1:0]   re_out_next, im_out_next;

    assign en2      = !m2_v_reg || !out_stall;
    assign en1      = !m1_v_reg || en2;
    assign up_ready = en1;

    // place octant values and signs
    assign swap        = up_beat.tag.oct[0] ^ up_beat.tag.oct[1];
    assign sin_abs     = swap ? up_beat.c15 : up_beat.s15;
    assign cos_abs     = swap ? up_beat.s15 : up_beat.c15;
    assign im_neg_next = up_beat.tag.oct[2];
    assign re_neg_next = up_beat.tag.oct[1] ^ up_beat.tag.oct[2];
    assign re_next     = (2*MAG_W)'(up_beat.tag.mag) * (2*MAG_W)'(cos_abs);
    assign im_next     = (2*MAG_W)'(up_beat.tag.mag) * (2*MAG_W)'(sin_abs);

    // truncate magnitude then apply sign
    assign re_mag      = m1_re_reg[2*MAG_W-1:15];
    assign im_mag      = m1_im_reg[2*MAG_W-1:15];
    assign re_out_next = m1_re_neg_reg ? OUT_W'(0) - re_mag : re_mag;
    assign im_out_next = m1_im_neg_reg ? OUT_W'(0) - im_mag : im_mag;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                m1_v_reg <= up_valid;
            end
            if (en2)
            begin
                m2_v_reg <= m1_v_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            m1_bin_reg    <= up_beat.tag.bin;
            m1_re_reg     <= re_next;
            m1_im_reg     <= im_next;
            m1_re_neg_reg <= re_neg_next;
            m1_im_neg_reg <= im_neg_next;
        end
        if (en2)
        begin
            m2_bin_reg <= m1_bin_reg;
            m2_re_reg  <= re_out_next;
            m2_im_reg  <= im_out_next;
        end
    end

    assign out_valid = m2_v_reg;
    assign out_bin   = m2_bin_reg;
    assign real_part = $signed(m2_re_reg);
    assign imag_part = $signed(m2_im_reg);

endmodule

`default_nettype wire

>>> hdl/phase_vocoder_bin_resynth.sv
// phase vocoder bin resynthesis top level: per-bin phase accumulation to rectangular output
// pipeline: 14 register stages between an accepted beat and its result
// throughput: one beat per clock while out_stall is low, set by the one read and one write port of the phase ram
// reset: control state clears at once, then a clearing pass zeroes every phase ram entry
// with in_stall held high; cfg_ready is always high
`default_nettype none

module phase_vocoder_bin_resynth #(
    parameter int NUM_BINS = pvr_pkg::NUM_BINS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pvr_pkg::SCALE_W-1:0]   phase_step_scale,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [pvr_pkg::BIN_W-1:0]     bin_index,
    input  wire logic [pvr_pkg::MAG_W-1:0]     magnitude,
    input  wire logic [pvr_pkg::FREQ_W-1:0]    frequency,
    input  wire logic                          start_fresh,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic        [pvr_pkg::BIN_W-1:0]   out_bin,
    output logic signed [pvr_pkg::OUT_W-1:0]   real_part,
    output logic signed [pvr_pkg::OUT_W-1:0]   imag_part
);

    import pvr_pkg::*;

    in_beat_t   in_beat;
    logic       in_ready;
    logic       phs_valid, phs_ready;
    phs_beat_t  phs_beat;
    logic       trig_valid, trig_ready;
    trig_beat_t trig_beat;

    assign cfg_ready = 1'b1;
    assign in_stall  = !in_ready;

    // input beat
    always_comb
    begin
        in_beat.bin   = bin_index;
        in_beat.mag   = magnitude;
        in_beat.freq  = frequency;
        in_beat.fresh = start_fresh;
    end

    pvr_phase #(
        .NUM_BINS (NUM_BINS)
    ) u_pvr_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (phase_step_scale),
        .up_valid  (in_valid),
        .up_ready  (in_ready),
        .up_beat   (in_beat),
        .dn_valid  (phs_valid),
        .dn_ready  (phs_ready),
        .dn_beat   (phs_beat)
    );

    pvr_trig u_pvr_trig (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (phs_valid),
        .up_ready (phs_ready),
        .up_beat  (phs_beat),
        .dn_valid (trig_valid),
        .dn_ready (trig_ready),
        .dn_beat  (trig_beat)
    );

    pvr_scale u_pvr_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (trig_valid),
        .up_ready  (trig_ready),
        .up_beat   (trig_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_bin   (out_bin),
        .real_part (real_part),
        .imag_part (imag_part)
    );

endmodule

`default_nettype wire

>>> hdl/pvr_checker.sv
// port-level checks for the bin resynthesis block and their bind
`default_nettype none

module pvr_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_stall,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic        [pvr_pkg::BIN_W-1:0]    out_bin,
    input wire logic signed [pvr_pkg::OUT_W-1:0]    real_part,
    input wire logic signed [pvr_pkg::OUT_W-1:0]    imag_part
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_bin) &&
        $stable(real_part) && $stable(imag_part))
        else $error("result beat changed while stalled");

    // result valid drops only after a beat was taken
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result valid dropped without a transfer");

    // the phase ram clearing pass holds off input right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input taken during phase clearing pass");

    // scaled values never reach the most negative code
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (real_part != 17'sh10000) && (imag_part != 17'sh10000))
        else $error("rectangular value out of range");

endmodule

bind phase_vocoder_bin_resynth pvr_checker u_pvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bin   (out_bin),
    .real_part (real_part),
    .imag_part (imag_part)
);

`default_nettype wire

>>> dv/tb_top.sv
// testbench for the phase vocoder bin resynthesis block: directed table, then random beats
`timescale 1ns / 100ps

module tb_top;

    import pvr_pkg::*;

    localparam int          N_BINS       = 1025;
    localparam logic [10:0] LAST_BIN     = 11'd1024;
    localparam logic [10:0] FIRST_OUTSIDE = 11'd1025;
    localparam logic [10:0] TOP_BIN      = 11'd2047;
    localparam logic [63:0] HALF_PI_TURN = 64'd6746518852;
    localparam logic [63:0] UNIT_Q30     = 64'd1073741824;
    localparam logic [31:0] OCTANT_TURN  = 32'd536870912;
    localparam logic [47:0] SCALE_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] SCALE_OCTANT = 48'h0001_0000_0000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SEGMENTS     = 6;
    localparam int          SEG_BEATS    = 158;

    typedef enum {ROW_SCALE, ROW_BEAT, ROW_KNOWN} row_kind_t;

    // one resynthesized bin as seen on the output
    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
    } bin_value_t;

    // one line of the directed table
    typedef struct {
        row_kind_t         kind;
        logic [SCALE_W-1:0] scale;
        logic [BIN_W-1:0]  bin;
        logic [MAG_W-1:0]  mag;
        logic [FREQ_W-1:0] freq;
        logic              fresh;
        logic [OUT_W-1:0]  re;
        logic [OUT_W-1:0]  im;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [SCALE_W-1:0] phase_step_scale;
    logic in_valid;
    logic in_stall;
    logic [BIN_W-1:0] bin_index;
    logic [MAG_W-1:0] magnitude;
    logic [FREQ_W-1:0] frequency;
    logic start_fresh;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [BIN_W-1:0] out_bin;
    logic signed [OUT_W-1:0] real_part;
    logic signed [OUT_W-1:0] imag_part;

    // predictor state
    logic [SCALE_W-1:0] step_scale;
    logic [PHASE_W-1:0] bin_phase_mem [0:N_BINS-1];
    bin_value_t pending_bins[$];

    int n_fail = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    phase_vocoder_bin_resynth dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .phase_step_scale (phase_step_scale),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .bin_index        (bin_index),
        .magnitude        (magnitude),
        .frequency        (frequency),
        .start_fresh      (start_fresh),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_bin          (out_bin),
        .real_part        (real_part),
        .imag_part        (imag_part)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // q30 product
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // sine and cosine over one octant, q1.15
    function automatic void octant_sincos(input logic [31:0] t, output int s15, output int c15);
        logic [63:0] x, x2, x3, x4, x5, x6, x7, x8, s, c;
        x  = (64'(t) * HALF_PI_TURN) >> 32;
        x2 = qmul(x, x);
        x3 = qmul(x2, x);
        x4 = qmul(x2, x2);
        x5 = qmul(x4, x);
        x6 = qmul(x4, x2);
        x7 = qmul(x6, x);
        x8 = qmul(x4, x4);
        s = x + x5 / 64'd120 - x3 / 64'd6 - x7 / 64'd5040;
        c = UNIT_Q30 + x4 / 64'd24 + x8 / 64'd40320 - x2 / 64'd2 - x6 / 64'd720;
        s15 = int'((s + 64'd16384) >> 15);
        c15 = int'((c + 64'd16384) >> 15);
    endfunction

    // fold a full-turn phase onto the first octant and place the result
    function automatic void phase_sincos(input logic [31:0] p, output int sn, output int cs);
        logic [2:0] oct;
        logic [31:0] r, t;
        int s0, c0;
        oct = p[31:29];
        r = {3'b000, p[28:0]};
        t = oct[0] ? OCTANT_TURN - r : r;
        octant_sincos(t, s0, c0);
        case (oct)
            3'd0: begin sn = s0;  cs = c0;  end
            3'd1: begin sn = c0;  cs = s0;  end
            3'd2: begin sn = c0;  cs = -s0; end
            3'd3: begin sn = s0;  cs = -c0; end
            3'd4: begin sn = -s0; cs = -c0; end
            3'd5: begin sn = -c0; cs = -s0; end
            3'd6: begin sn = -c0; cs = s0;  end
            default: begin sn = -s0; cs = c0; end
        endcase
    endfunction

    // magnitude times trig value, truncated toward zero, sign applied last
    function automatic logic [OUT_W-1:0] mag_times(input logic [MAG_W-1:0] mag, input int trig);
        logic [31:0] a, v;
        a = (trig < 0) ? 32'(-trig) : 32'(trig);
        v = (32'(mag) * a) >> 15;
        return (trig < 0) ? OUT_W'(32'h20000 - v) : OUT_W'(v);
    endfunction

    // advance the bin's phase accumulator and rotate the magnitude onto it
    function automatic bin_value_t rotate_bin(input logic [BIN_W-1:0] bin,
                                              input logic [MAG_W-1:0] mag,
                                              input logic [FREQ_W-1:0] freq,
                                              input logic fresh);
        logic [63:0] hi_part, lo_part;
        logic [31:0] adv, ph;
        int sn, cs;
        bin_value_t res;
        hi_part = 64'(freq) * 64'(step_scale[47:24]);
        lo_part = (64'(freq) * 64'(step_scale[23:0])) >> 24;
        adv = 32'(hi_part + lo_part);
        if (bin < N_BINS)
        begin
            ph = (fresh ? 32'd0 : bin_phase_mem[bin]) + adv;
            bin_phase_mem[bin] = ph;
        end
        else
        begin
            // no accumulator behind this bin
            ph = adv;
        end
        phase_sincos(ph, sn, cs);
        res.bin = bin;
        res.re = mag_times(mag, cs);
        res.im = mag_times(mag, sn);
        return res;
    endfunction

    function automatic stim_row_t beat_row(input row_kind_t kind, input logic [BIN_W-1:0] bin,
                                           input logic [MAG_W-1:0] mag,
                                           input logic [FREQ_W-1:0] freq, input logic fresh,
                                           input int re, input int im);
        stim_row_t row;
        row.kind = kind;
        row.scale = '0;
        row.bin = bin;
        row.mag = mag;
        row.freq = freq;
        row.fresh = fresh;
        row.re = OUT_W'(re);
        row.im = OUT_W'(im);
        return row;
    endfunction

    function automatic stim_row_t scale_row(input logic [SCALE_W-1:0] scale);
        stim_row_t row;
        row = beat_row(ROW_SCALE, '0, '0, '0, 1'b0, 0, 0);
        row.scale = scale;
        return row;
    endfunction

    // offer one beat, wait for it to be taken, then book its expected value
    task automatic send_bin(input logic [BIN_W-1:0] bin, input logic [MAG_W-1:0] mag,
                            input logic [FREQ_W-1:0] freq, input logic fresh,
                            input logic known, input bin_value_t typed);
        bin_value_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        bin_index <= bin;
        magnitude <= mag;
        frequency <= freq;
        start_fresh <= fresh;
        do @(posedge clk); while (in_stall !== 1'b0);
        want = rotate_bin(bin, mag, freq, fresh);
        if (known)
            want = typed;
        pending_bins = {pending_bins, want};
    endtask

    // stop sending and wait until every booked value has come out
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_bins.size() != 0) @(negedge clk);
    endtask

    // write the scale register while the block is idle
    task automatic write_step_scale(input logic [SCALE_W-1:0] v);
        drain();
        @(posedge clk);
        cfg_valid <= 1'b1;
        phase_step_scale <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        step_scale = v;
    endtask

    // output side: check each accepted beat and decide the next stall
    always @(posedge clk)
    begin : rx_side
        bin_value_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_bins.size() == 0)
            begin
                $error("out_bin: expected nothing, got %0d", out_bin);
                n_fail++;
            end
            else
            begin
                want = pending_bins.pop_front();
                if (out_bin !== want.bin)
                begin
                    $error("out_bin: expected %0d, got %0d", want.bin, out_bin);
                    n_fail++;
                end
                if (real_part !== want.re)
                begin
                    $error("real_part: expected %0d, got %0d", $signed(want.re), real_part);
                    n_fail++;
                end
                if (imag_part !== want.im)
                begin
                    $error("imag_part: expected %0d, got %0d", $signed(want.im), imag_part);
                    n_fail++;
                end
            end
        end
        // one long hold-off, otherwise random stalls
        if (hold_go && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // stimulus
    initial
    begin
        stim_row_t rows[$];
        bin_value_t typed;
        logic [BIN_W-1:0] bin, prev_bin;
        logic [MAG_W-1:0] mag;
        logic [FREQ_W-1:0] freq;
        logic fresh;
        logic [SCALE_W-1:0] scale;
        int r;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        phase_step_scale = '0;
        in_valid = 1'b0;
        bin_index = '0;
        magnitude = '0;
        frequency = '0;
        start_fresh = 1'b0;
        step_scale = '0;
        prev_bin = '0;
        for (int i = 0; i < N_BINS; i++)
            bin_phase_mem[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset scale is zero: phase stays at zero, so real is the magnitude
        rows = {rows, beat_row(ROW_KNOWN, 11'd0, 16'hFFFF, 24'hFFFFFF, 1'b0, 65535, 0)};
        rows = {rows, beat_row(ROW_KNOWN, LAST_BIN, 16'h0100, 24'h000000, 1'b1, 256, 0)};
        rows = {rows, beat_row(ROW_KNOWN, TOP_BIN, 16'hFFFF, 24'hFFFFFF, 1'b1, 65535, 0)};
        rows = {rows, beat_row(ROW_KNOWN, FIRST_OUTSIDE, 16'h0000, 24'h00007B, 1'b0, 0, 0)};
        // one octant per beat on the same bin, through all eight and past the wrap
        rows = {rows, scale_row(SCALE_OCTANT)};
        for (int i = 0; i < 9; i++)
            rows = {rows, beat_row(ROW_BEAT, 11'd5, 16'h8000, 24'h200000, 1'b0, 0, 0)};
        // start of channel clears the accumulator
        rows = {rows, beat_row(ROW_BEAT, 11'd5, 16'h8000, 24'h200000, 1'b1, 0, 0)};
        rows = {rows, beat_row(ROW_BEAT, TOP_BIN, 16'h7FFF, 24'h600000, 1'b0, 0, 0)};
        // largest scale and frequency
        rows = {rows, scale_row(SCALE_MAX)};
        rows = {rows, beat_row(ROW_BEAT, LAST_BIN, 16'hFFFF, 24'hFFFFFF, 1'b0, 0, 0)};
        rows = {rows, beat_row(ROW_BEAT, LAST_BIN, 16'hFFFF, 24'hFFFFFF, 1'b0, 0, 0)};
        rows = {rows, beat_row(ROW_BEAT, 11'd0, 16'h0001, 24'h000001, 1'b1, 0, 0)};
        rows = {rows, beat_row(ROW_BEAT, 11'd1500, 16'hFFFF, 24'hFFFFFF, 1'b0, 0, 0)};
        rows = {rows, beat_row(ROW_KNOWN, 11'd3, 16'hABCD, 24'h000000, 1'b1, 43981, 0)};

        send_idle_pct = 7;
        recv_idle_pct = 68;
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_SCALE)
                write_step_scale(rows[i].scale);
            else
            begin
                typed.bin = rows[i].bin;
                typed.re = rows[i].re;
                typed.im = rows[i].im;
                send_bin(rows[i].bin, rows[i].mag, rows[i].freq, rows[i].fresh,
                         rows[i].kind == ROW_KNOWN, typed);
            end
        end

        // random segments, each with its own scale; each pair of segments shares an idling pattern
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: scale = SCALE_W'({$urandom, $urandom});
                1: scale = '0;
                2: scale = SCALE_MAX;
                3: scale = SCALE_OCTANT;
                4: scale = SCALE_W'({$urandom_range(1023), $urandom}) << 4;
                default: scale = SCALE_W'({$urandom, $urandom});
            endcase
            write_step_scale(scale);
            if (seg < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 68;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // output blocked for a long stretch while beats keep coming
            if (seg == 4)
                hold_go = 1'b1;

            for (int n = 0; n < SEG_BEATS; n++)
            begin
                // favor repeats and a few hot bins so accumulators really build up
                r = $urandom_range(99);
                if (r < 30)
                    bin = prev_bin;
                else if (r < 55)
                    bin = BIN_W'($urandom_range(7));
                else if (r < 85)
                    bin = BIN_W'($urandom_range(N_BINS - 1));
                else if (r < 95)
                    bin = BIN_W'($urandom_range(TOP_BIN, FIRST_OUTSIDE));
                else
                begin
                    case ($urandom_range(3))
                        0: bin = '0;
                        1: bin = LAST_BIN;
                        2: bin = FIRST_OUTSIDE;
                        default: bin = TOP_BIN;
                    endcase
                end
                prev_bin = bin;

                r = $urandom_range(99);
                if (r < 10)
                    mag = '0;
                else if (r < 20)
                    mag = '1;
                else
                    mag = MAG_W'($urandom);

                r = $urandom_range(99);
                if (r < 8)
                    freq = '0;
                else if (r < 16)
                    freq = '1;
                else if (r < 40)
                    freq = FREQ_W'($urandom_range(65535));
                else
                    freq = FREQ_W'($urandom);

                fresh = ($urandom_range(99) < 10);
                send_bin(bin, mag, freq, fresh, 1'b0, typed);
            end
        end

        // let everything come out, then watch for strays
        drain();
        repeat (30) @(posedge clk);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> phase_vocoder_bin_resynth.f
hdl/pvr_pkg.sv
hdl/pvr_ram.sv
hdl/pvr_phase.sv
hdl/pvr_trig.sv
hdl/pvr_scale.sv
hdl/phase_vocoder_bin_resynth.sv
hdl/pvr_checker.sv
dv/tb_top.sv
